// ===== src/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// sab_pkg - shared types and constants of the stream affinity balancer
// Request codes, item record passed from front to back, field widths.
// ----------------------------------------------------------------------------
package sab_pkg;

   localparam int ACNT_W      = 16;
   localparam int QCNT_W      = 32;
   localparam int N_W         = 4;
   localparam int CUR_W       = 3;
   localparam int JOB_W       = 3;
   localparam int MASK_W      = 8;
   localparam int Q_W         = 3;
   localparam int MOD_STEP    = 4;
   localparam int MOD_CYC     = QCNT_W / MOD_STEP;
   localparam int MOD_CNT_W   = $clog2(MOD_CYC);
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;
   localparam int FIFO_CNT_W  = 2;

   localparam logic [2:0] REQ_CREATE  = 3'd0;
   localparam logic [2:0] REQ_DESTROY = 3'd1;
   localparam logic [2:0] REQ_ADD_JOB = 3'd2;
   localparam logic [2:0] REQ_SET     = 3'd3;
   localparam logic [2:0] REQ_QUERY   = 3'd4;
   localparam logic [2:0] REQ_CLEAR   = 3'd5;

   localparam logic [2:0] JOB_RECORD_EVENT = 3'd6;

   localparam logic [CSR_ADDR_W-1:0] CSR_BY_JOB_TYPE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_AFF     = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CREATE,
      OP_DESTROY,
      OP_MASK,
      OP_RR,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [N_W-1:0]     n;
      logic [CUR_W-1:0]   cur;
      logic [MASK_W-1:0]  mask;
      logic               all_ok;
      logic [Q_W-1:0]     q;
      logic [N_W-1:0]     sel;
      logic               status;
      logic               dec_en;
   } item_type;

   function automatic logic [Q_W-1:0] job_queue(input logic [JOB_W-1:0] job);
      logic [Q_W-1:0] q;
      case (job)
         3'd0:    q = 3'd1;
         3'd1:    q = 3'd0;
         3'd2:    q = 3'd0;
         3'd3:    q = 3'd2;
         3'd4:    q = 3'd3;
         3'd5:    q = 3'd4;
         default: q = 3'd0;
      endcase
      return q;
   endfunction

endpackage

// ===== src/stream_affinity_balancer.sv =====
// ----------------------------------------------------------------------------
// stream_affinity_balancer - least-loaded affinity placement for streams
// Front classifies requests, a two-entry queue decouples it from the back
// end that updates usage counters and forms one result per request.
// ----------------------------------------------------------------------------
//  channel  ports         direction  payload
//  request  req_tvalid..  in         tdata: req_type, cur_affinity,
//                                    stream_locked, job_type, affinity_mask
//  result   rsp_tvalid..  out        tdata: new_affinity, status
//  config   csr_we..      in         0 by_job_type, 1 num_affinities
//
//  Steps per item: results only go straight out, create and destroy update one
//  counter, query scans, set and add job by mask release, scan (one counter read
//  per cycle during the scan) and claim, round-robin add job releases, divides
//  (remainder unit, 4 dividend bits a cycle) and claims.
//  Synchronous reset clears all counters and config at once.
//  Up to two items queue while the back end works or the result stalls.
// ----------------------------------------------------------------------------
module stream_affinity_balancer #(
   parameter int MAX_AFFINITIES  = 8,
   parameter int NUM_QUEUE_TYPES = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] req_type, [5:3] cur_affinity, [6] stream_locked,
   // [9:7] job_type, [17:10] affinity_mask
   input  logic [sab_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] new_affinity, [3] status
   output logic [sab_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [sab_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sab_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic              push;
   logic              full;
   logic              pop;
   logic              empty;
   sab_pkg::item_type push_item;
   sab_pkg::item_type pop_item;

   sab_front #(
      .MAX_AFFINITIES  (MAX_AFFINITIES),
      .NUM_QUEUE_TYPES (NUM_QUEUE_TYPES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_item  (push_item),
      .full       (full)
   );

   sab_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   sab_back #(
      .MAX_AFFINITIES  (MAX_AFFINITIES),
      .NUM_QUEUE_TYPES (NUM_QUEUE_TYPES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/sab_fifo.sv =====
// ----------------------------------------------------------------------------
// sab_fifo - two-entry queue between front and back
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module sab_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sab_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output sab_pkg::item_type pop_item,
   output logic              empty
);

   sab_pkg::item_type                   entries_ff [sab_pkg::FIFO_DEPTH];
   logic [sab_pkg::FIFO_PTR_W-1:0]      wr_ff;
   logic [sab_pkg::FIFO_PTR_W-1:0]      rd_ff;
   logic [sab_pkg::FIFO_CNT_W-1:0]      cnt_ff;

   assign full     = (cnt_ff == sab_pkg::FIFO_CNT_W'(sab_pkg::FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = entries_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            entries_ff[wr_ff] <= push_item;
            wr_ff             <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/sab_front.sv =====
// ----------------------------------------------------------------------------
// sab_front - request intake and classification
// Holds the configuration registers and turns each request into an item
// telling the back end which counter steps to run.
// ----------------------------------------------------------------------------
module sab_front #(
   parameter int MAX_AFFINITIES  = 8,
   parameter int NUM_QUEUE_TYPES = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sab_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sab_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sab_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               push,
   output sab_pkg::item_type                  push_item,
   input  logic                               full
);

   logic                        by_job_ff;
   logic [sab_pkg::N_W-1:0]     num_aff_ff;
   logic [sab_pkg::N_W-1:0]     n;
   logic [2:0]                  req_type;
   logic [sab_pkg::CUR_W-1:0]   cur;
   logic                        locked;
   logic [sab_pkg::JOB_W-1:0]   job;
   logic [sab_pkg::MASK_W-1:0]  mask;
   logic [sab_pkg::Q_W-1:0]     q;
   logic                        cur_ok;
   sab_pkg::item_type           it;

   always_ff @(posedge clock) begin
      if (reset) begin
         by_job_ff  <= 1'b0;
         num_aff_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            sab_pkg::CSR_BY_JOB_TYPE: by_job_ff  <= csr_wdata[0];
            sab_pkg::CSR_NUM_AFF:     num_aff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_type = req_tdata[2:0];
   assign cur      = req_tdata[5:3];
   assign locked   = req_tdata[6];
   assign job      = req_tdata[9:7];
   assign mask     = req_tdata[17:10];

   always_comb begin
      if (int'(num_aff_ff) > MAX_AFFINITIES) begin
         n = sab_pkg::N_W'(MAX_AFFINITIES);
      end else begin
         n = num_aff_ff;
      end
   end

   assign q      = sab_pkg::job_queue(job);
   assign cur_ok = ({1'b0, cur} < n);

   always_comb begin
      it        = '0;
      it.op     = sab_pkg::OP_NONE;
      it.n      = n;
      it.cur    = cur;
      it.mask   = mask;
      it.q      = q;
      it.status = 1'b1;
      case (req_type)
         sab_pkg::REQ_CREATE: begin
            if (n != '0) begin
               it.op     = sab_pkg::OP_CREATE;
               it.status = 1'b0;
            end
         end
         sab_pkg::REQ_DESTROY: begin
            it.sel = {1'b0, cur};
            if (cur_ok) begin
               it.op     = sab_pkg::OP_DESTROY;
               it.dec_en = 1'b1;
               it.status = 1'b0;
            end
         end
         sab_pkg::REQ_ADD_JOB: begin
            it.sel = {1'b0, cur};
            if (locked) begin
               it.status = 1'b0;
            end else if (by_job_ff) begin
               if (job >= sab_pkg::JOB_RECORD_EVENT) begin
                  it.status = 1'b0;
               end else if (n != '0 && int'(q) < NUM_QUEUE_TYPES) begin
                  it.op     = sab_pkg::OP_RR;
                  it.dec_en = cur_ok;
                  it.status = 1'b0;
               end
            end else if (n != '0) begin
               it.op     = sab_pkg::OP_MASK;
               it.mask   = sab_pkg::MASK_W'(1);
               it.dec_en = cur_ok;
               it.status = 1'b0;
            end
         end
         sab_pkg::REQ_SET: begin
            it.sel = {1'b0, cur};
            if (!locked && n != '0) begin
               it.op     = sab_pkg::OP_MASK;
               it.dec_en = cur_ok;
               it.status = 1'b0;
            end
         end
         sab_pkg::REQ_QUERY: begin
            if (n != '0) begin
               it.op     = sab_pkg::OP_QUERY;
               it.all_ok = 1'b1;
               it.status = 1'b0;
            end
         end
         sab_pkg::REQ_CLEAR: begin
            it.op     = sab_pkg::OP_CLEAR;
            it.status = 1'b0;
         end
         default: ;
      endcase
   end

   assign req_tready = !full;
   assign push       = req_tvalid && !full;
   assign push_item  = it;

endmodule

// ===== src/sab_mod.sv =====
// ----------------------------------------------------------------------------
// sab_mod - iterative remainder unit
// Queue counter modulo affinity count, a few dividend bits per cycle.
// ----------------------------------------------------------------------------
module sab_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sab_pkg::QCNT_W-1:0]     dividend,
   input  logic [sab_pkg::N_W-1:0]        divisor,
   output logic                           done,
   output logic [sab_pkg::N_W-1:0]        rem
);

   logic [sab_pkg::QCNT_W-1:0]     dvd_ff;
   logic [sab_pkg::N_W-1:0]        div_ff;
   logic [sab_pkg::N_W-1:0]        rem_ff;
   logic [sab_pkg::N_W-1:0]        rem_in;
   logic [sab_pkg::MOD_CNT_W-1:0]  cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   always_comb begin
      logic [sab_pkg::N_W:0] t;
      rem_in = rem_ff;
      for (int k = 0; k < sab_pkg::MOD_STEP; k++) begin
         t = {rem_in, dvd_ff[sab_pkg::QCNT_W-1-k]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         rem_in = t[sab_pkg::N_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (start) begin
            dvd_ff  <= dividend;
            div_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end else if (busy_ff) begin
            dvd_ff <= dvd_ff << sab_pkg::MOD_STEP;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == sab_pkg::MOD_CNT_W'(sab_pkg::MOD_CYC - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== src/sab_back.sv =====
// ----------------------------------------------------------------------------
// sab_back - counter sequencer
// Owns the usage counters; releases, scans, divides and claims per item,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module sab_back #(
   parameter int MAX_AFFINITIES  = 8,
   parameter int NUM_QUEUE_TYPES = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               empty,
   input  sab_pkg::item_type                  pop_item,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sab_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int AN = (MAX_AFFINITIES < 15) ? MAX_AFFINITIES : 15;
   localparam int AW = (AN > 1) ? $clog2(AN) : 1;
   localparam int QW = (NUM_QUEUE_TYPES > 1) ? $clog2(NUM_QUEUE_TYPES) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC,
      S_SCAN,
      S_MOD,
      S_INC,
      S_DONE
   } state_type;

   state_type                      state_ff;
   sab_pkg::item_type              item_ff;
   logic [sab_pkg::N_W-1:0]        sel_ff;
   logic [sab_pkg::N_W-1:0]        scan_ff;
   logic [sab_pkg::ACNT_W-1:0]     best_ff;
   logic [sab_pkg::N_W-1:0]        best_idx_ff;
   logic                           found_ff;
   logic                           rsp_valid_ff;
   logic [sab_pkg::CUR_W-1:0]      rsp_aff_ff;
   logic                           rsp_status_ff;

   logic [sab_pkg::ACNT_W-1:0]     acnt_ff [AN];
   logic [sab_pkg::QCNT_W-1:0]     qcnt_ff [NUM_QUEUE_TYPES];

   logic [AW-1:0]                  acnt_ridx;
   logic [sab_pkg::ACNT_W-1:0]     acnt_rd;
   logic                           acnt_we;
   logic [sab_pkg::ACNT_W-1:0]     acnt_wdata;
   logic [QW-1:0]                  qidx;
   logic                           clear_all;
   logic                           mod_start;
   logic                           mod_done;
   logic [sab_pkg::N_W-1:0]        mod_rem;
   logic                           scan_ok;
   logic                           scan_hit;
   logic                           scan_last;

   sab_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (qcnt_ff[qidx]),
      .divisor  (item_ff.n),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   assign pop       = (state_ff == S_IDLE) && !empty;
   assign clear_all = pop && (pop_item.op == sab_pkg::OP_CLEAR);
   assign qidx      = QW'(item_ff.q);
   assign mod_start = (state_ff == S_DEC) && (item_ff.op == sab_pkg::OP_RR);

   always_comb begin
      case (state_ff)
         S_DEC:   acnt_ridx = AW'(item_ff.cur);
         S_INC:   acnt_ridx = AW'(sel_ff);
         default: acnt_ridx = AW'(scan_ff);
      endcase
   end

   assign acnt_rd = acnt_ff[acnt_ridx];

   always_comb begin
      acnt_we    = 1'b0;
      acnt_wdata = acnt_rd;
      case (state_ff)
         S_DEC: begin
            if (item_ff.dec_en && acnt_rd != '0) begin
               acnt_we    = 1'b1;
               acnt_wdata = acnt_rd - 1'b1;
            end
         end
         S_INC: begin
            if (acnt_rd != '1) begin
               acnt_we    = 1'b1;
               acnt_wdata = acnt_rd + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign scan_ok   = item_ff.all_ok ||
                      (scan_ff < sab_pkg::N_W'(sab_pkg::MASK_W) && item_ff.mask[scan_ff[2:0]]);
   assign scan_hit  = scan_ok && (!found_ff || acnt_rd < best_ff);
   assign scan_last = (scan_ff == item_ff.n - 1'b1);

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < AN; i++) begin
            acnt_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_QUEUE_TYPES; i++) begin
            qcnt_ff[i] <= '0;
         end
      end else begin
         if (acnt_we) begin
            acnt_ff[acnt_ridx] <= acnt_wdata;
         end
         if (mod_start) begin
            qcnt_ff[qidx] <= qcnt_ff[qidx] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  item_ff     <= pop_item;
                  sel_ff      <= pop_item.sel;
                  scan_ff     <= '0;
                  best_idx_ff <= '0;
                  found_ff    <= 1'b0;
                  case (pop_item.op)
                     sab_pkg::OP_NONE,
                     sab_pkg::OP_CLEAR:  state_ff <= S_DONE;
                     sab_pkg::OP_CREATE: state_ff <= S_INC;
                     default:            state_ff <= S_DEC;
                  endcase
               end
            end
            S_DEC: begin
               case (item_ff.op)
                  sab_pkg::OP_MASK,
                  sab_pkg::OP_QUERY: state_ff <= S_SCAN;
                  sab_pkg::OP_RR:    state_ff <= S_MOD;
                  default:           state_ff <= S_DONE;
               endcase
            end
            S_SCAN: begin
               if (scan_hit) begin
                  best_ff     <= acnt_rd;
                  best_idx_ff <= scan_ff;
                  found_ff    <= 1'b1;
               end
               if (scan_last) begin
                  sel_ff   <= scan_hit ? scan_ff : best_idx_ff;
                  state_ff <= (item_ff.op == sab_pkg::OP_QUERY) ? S_DONE : S_INC;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  sel_ff   <= mod_rem;
                  state_ff <= S_INC;
               end
            end
            S_INC: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_aff_ff    <= sel_ff[sab_pkg::CUR_W-1:0];
                  rsp_status_ff <= item_ff.status;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sab_pkg::RSP_TDATA_W - sab_pkg::CUR_W - 1){1'b0}},
                        rsp_status_ff, rsp_aff_ff};

   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("remainder finished outside the divide step");

   a_mod_rem_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> mod_rem < item_ff.n)
      else $error("remainder not below affinity count");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_ff < item_ff.n)
      else $error("scan index past affinity count");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule
